// ===== hw/rtl/ipfe_pkg.sv =====
// Types, codes and reset values shared by the infrared pulse frame encoder.
package ipfe_pkg;

	localparam int         CFG_W          = 16;
	localparam int         CFG_IDX_W      = 3;
	localparam int         CONST_W        = 3;
	localparam logic [15:0] RST_HEADER_MARK  = 16'd9000;
	localparam logic [15:0] RST_HEADER_SPACE = 16'd4500;
	localparam logic [15:0] RST_BIT_MARK     = 16'd500;
	localparam logic [15:0] RST_ONE_SPACE    = 16'd1660;
	localparam logic [15:0] RST_ZERO_SPACE   = 16'd600;
	// Trailer zero cells after the first one, counted down by the loop step.
	localparam logic [CONST_W-1:0] TRAIL_ZERO_REST = 3'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER_MARK  = 3'd0,
		REG_HEADER_SPACE = 3'd1,
		REG_BIT_MARK     = 3'd2,
		REG_ONE_SPACE    = 3'd3,
		REG_ZERO_SPACE   = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_TRAILER = 2'd2,
		KIND_FOOTER  = 2'd3
	} cell_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_HEADER   = 3'd1,
		ST_PAYLOAD  = 3'd2,
		ST_TRAIL_Z0 = 3'd3,
		ST_TRAIL_Z  = 3'd4,
		ST_TRAIL_O0 = 3'd5,
		ST_TRAIL_O1 = 3'd6,
		ST_FOOTER   = 3'd7
	} step_t;

	typedef enum logic {
		MARK_HEADER = 1'b0,
		MARK_BIT    = 1'b1
	} mark_sel_t;

	typedef enum logic [2:0] {
		SPACE_HEADER = 3'd0,
		SPACE_ONE    = 3'd1,
		SPACE_ZERO   = 3'd2,
		SPACE_DATA   = 3'd3,
		SPACE_NONE   = 3'd4
	} space_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD  = 2'd0,
		CNT_BITS  = 2'd1,
		CNT_CONST = 2'd2,
		CNT_DEC   = 2'd3
	} cnt_op_t;

	typedef enum logic [1:0] {
		SEQ_WAIT  = 2'd0,
		SEQ_GOTO  = 2'd1,
		SEQ_LOOP  = 2'd2,
		SEQ_SKIPZ = 2'd3
	} seq_op_t;

	typedef struct packed {
		logic               emit;
		cell_kind_t         kind;
		mark_sel_t          mark_sel;
		space_sel_t         space_sel;
		logic               last;
		cnt_op_t            cnt_op;
		logic [CONST_W-1:0] cnt_const;
		seq_op_t            seq_op;
		step_t              target;
	} ctrl_word_t;

	typedef struct packed {
		logic slot_free;
		logic cnt_zero;
		logic cnt_one;
	} dp_status_t;

	typedef struct packed {
		logic [31:0] data_word;
		logic [5:0]  bit_count;
	} in_t;

	typedef struct packed {
		logic [1:0]  cell_kind;
		logic [15:0] mark_us;
		logic [15:0] space_us;
		logic        last_cell;
	} out_t;

endpackage

// ===== hw/rtl/ipfe_ucode.sv =====
// Microcode store: one control word for each step of the frame program.
module ipfe_ucode (
	input  ipfe_pkg::step_t      step,
	output ipfe_pkg::ctrl_word_t cw
);
	import ipfe_pkg::*;

	always_comb begin
		cw = '{emit: 1'b0, kind: KIND_HEADER, mark_sel: MARK_BIT, space_sel: SPACE_NONE,
			last: 1'b0, cnt_op: CNT_HOLD, cnt_const: '0, seq_op: SEQ_WAIT, target: ST_IDLE};
		unique case (step)
			ST_IDLE: begin
				cw.cnt_op = CNT_BITS;
				cw.seq_op = SEQ_WAIT;
				cw.target = ST_HEADER;
			end
			ST_HEADER: begin
				cw.emit      = 1'b1;
				cw.kind      = KIND_HEADER;
				cw.mark_sel  = MARK_HEADER;
				cw.space_sel = SPACE_HEADER;
				cw.seq_op    = SEQ_SKIPZ;
				cw.target    = ST_TRAIL_Z0;
			end
			ST_PAYLOAD: begin
				cw.emit      = 1'b1;
				cw.kind      = KIND_PAYLOAD;
				cw.space_sel = SPACE_DATA;
				cw.cnt_op    = CNT_DEC;
				cw.seq_op    = SEQ_LOOP;
				cw.target    = ST_TRAIL_Z0;
			end
			ST_TRAIL_Z0: begin
				cw.emit      = 1'b1;
				cw.kind      = KIND_TRAILER;
				cw.space_sel = SPACE_ZERO;
				cw.cnt_op    = CNT_CONST;
				cw.cnt_const = TRAIL_ZERO_REST;
				cw.seq_op    = SEQ_GOTO;
				cw.target    = ST_TRAIL_Z;
			end
			ST_TRAIL_Z: begin
				cw.emit      = 1'b1;
				cw.kind      = KIND_TRAILER;
				cw.space_sel = SPACE_ZERO;
				cw.cnt_op    = CNT_DEC;
				cw.seq_op    = SEQ_LOOP;
				cw.target    = ST_TRAIL_O0;
			end
			ST_TRAIL_O0: begin
				cw.emit      = 1'b1;
				cw.kind      = KIND_TRAILER;
				cw.space_sel = SPACE_ONE;
				cw.seq_op    = SEQ_GOTO;
				cw.target    = ST_TRAIL_O1;
			end
			ST_TRAIL_O1: begin
				cw.emit      = 1'b1;
				cw.kind      = KIND_TRAILER;
				cw.space_sel = SPACE_ONE;
				cw.seq_op    = SEQ_GOTO;
				cw.target    = ST_FOOTER;
			end
			ST_FOOTER: begin
				cw.emit      = 1'b1;
				cw.kind      = KIND_FOOTER;
				cw.space_sel = SPACE_NONE;
				cw.last      = 1'b1;
				cw.seq_op    = SEQ_GOTO;
				cw.target    = ST_IDLE;
			end
			default: begin
				cw.seq_op = SEQ_GOTO;
				cw.target = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ipfe_datapath.sv =====
// Datapath: duration registers, payload word, loop counter and output register.
module ipfe_datapath #(
	parameter int DATA_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  ipfe_pkg::in_t        in_data,
	input  ipfe_pkg::ctrl_word_t cw,
	input  logic                 step_en,
	input  logic                 out_stall,
	output logic                 out_valid,
	output ipfe_pkg::out_t       out_data,
	output ipfe_pkg::dp_status_t status
);
	import ipfe_pkg::*;

	localparam int CNT_W = $clog2(DATA_BITS + 1);

	logic [15:0]      header_mark_q;
	logic [15:0]      header_space_q;
	logic [15:0]      bit_mark_q;
	logic [15:0]      one_space_q;
	logic [15:0]      zero_space_q;
	logic [31:0]      word_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_sat;
	logic [6:0]       bit_idx;
	logic             data_bit;
	logic             out_valid_q;
	out_t             out_q;
	out_t             next_cell;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_mark_q  <= RST_HEADER_MARK;
			header_space_q <= RST_HEADER_SPACE;
			bit_mark_q     <= RST_BIT_MARK;
			one_space_q    <= RST_ONE_SPACE;
			zero_space_q   <= RST_ZERO_SPACE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER_MARK:  header_mark_q  <= cfg_data;
				REG_HEADER_SPACE: header_space_q <= cfg_data;
				REG_BIT_MARK:     bit_mark_q     <= cfg_data;
				REG_ONE_SPACE:    one_space_q    <= cfg_data;
				REG_ZERO_SPACE:   zero_space_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// A request asking for more bits than the word holds is clipped.
	assign cnt_sat = (int'(in_data.bit_count) > DATA_BITS) ? CNT_W'(DATA_BITS)
		: CNT_W'(in_data.bit_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (step_en) begin
			case (cw.cnt_op)
				CNT_BITS:  cnt_q <= cnt_sat;
				CNT_CONST: cnt_q <= CNT_W'(cw.cnt_const);
				CNT_DEC:   cnt_q <= cnt_q - CNT_W'(1);
				default:   cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && cw.cnt_op == CNT_BITS) begin
			word_q <= in_data.data_word;
		end
	end

	// Bit positions beyond the input word send as zero.
	assign bit_idx  = 7'(cnt_q) - 7'd1;
	assign data_bit = (bit_idx < 7'd32) ? word_q[bit_idx[4:0]] : 1'b0;

	always_comb begin
		next_cell.cell_kind = cw.kind;
		next_cell.last_cell = cw.last;
		next_cell.mark_us   = (cw.mark_sel == MARK_HEADER) ? header_mark_q : bit_mark_q;
		case (cw.space_sel)
			SPACE_HEADER: next_cell.space_us = header_space_q;
			SPACE_ONE:    next_cell.space_us = one_space_q;
			SPACE_ZERO:   next_cell.space_us = zero_space_q;
			SPACE_DATA:   next_cell.space_us = data_bit ? one_space_q : zero_space_q;
			default:      next_cell.space_us = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && cw.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && cw.emit) begin
			out_q <= next_cell;
		end
	end

	assign status.slot_free = !out_valid_q || !out_stall;
	assign status.cnt_zero  = (cnt_q == '0);
	assign status.cnt_one   = (cnt_q == CNT_W'(1));
	assign out_valid        = out_valid_q;
	assign out_data         = out_q;

endmodule

// ===== hw/rtl/ir_pulse_frame_encoder.sv =====
// Top level of the infrared pulse-distance frame encoder.
//
// One request on the input channel carries a data word and a bit count. It
// becomes a frame of bit_count + 10 cells on the output channel: a header,
// one payload cell per bit (most significant used bit first), six zero and
// two one trailer cells, and a footer flagged by last_cell. A bit count above
// DATA_BITS is clipped to DATA_BITS.
// A small microprogram of eight steps, held in the control store and walked by
// a step counter with conditional jumps, drives the datapath; a loop counter
// runs the payload and trailer loops.
// The header is registered into the output register once the request is taken;
// the output register then takes one cell a cycle while out_stall is low, and the
// next request is taken only once the footer step has returned to idle.
// The user must write the durations through the cfg port only while idle; the
// block does not enforce this. An index beyond the register list is ignored.
// Reset returns the durations to their defaults and the sequencer to idle.
// A stall on the output holds the current cell and the program waits.
module ir_pulse_frame_encoder #(
	parameter int DATA_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  ipfe_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output ipfe_pkg::out_t out_data
);
	import ipfe_pkg::*;

	step_t      step_q;
	step_t      step_d;
	ctrl_word_t cw;
	dp_status_t status;
	logic       step_en;

	ipfe_ucode u_ucode (
		.step (step_q),
		.cw   (cw)
	);

	ipfe_datapath #(
		.DATA_BITS (DATA_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cw        (cw),
		.step_en   (step_en),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.status    (status)
	);

	assign in_stall = (cw.seq_op != SEQ_WAIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// A step that emits a cell only moves on once the output register has room.
	always_comb begin
		if (cw.seq_op == SEQ_WAIT) begin
			step_en = in_valid;
		end else begin
			step_en = cw.emit && status.slot_free;
		end
		step_d = step_q;
		if (step_en) begin
			unique case (cw.seq_op)
				SEQ_WAIT:  step_d = cw.target;
				SEQ_GOTO:  step_d = cw.target;
				SEQ_LOOP:  step_d = status.cnt_one ? cw.target : step_q;
				SEQ_SKIPZ: step_d = status.cnt_zero ? cw.target : step_t'(step_q + 3'd1);
				default:   step_d = ST_IDLE;
			endcase
		end
	end

endmodule
